@@ rtl/core/gas_sensor_frame_median_filter_macros.svh @@
// assertion macros shared by the median filter modules
`ifndef GAS_SENSOR_FRAME_MEDIAN_FILTER_MACROS_SVH
`define GAS_SENSOR_FRAME_MEDIAN_FILTER_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define GSFM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define GSFM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/gsfm_pkg.sv @@
// shared constants, types and crc function for the gas sensor median filter
package gsfm_pkg;

	localparam int unsigned HISTORY_DEPTH_DEF = 5;
	localparam int unsigned VAL_W = 16;

	localparam logic [7:0] CRC_INIT = 8'hFF;
	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [15:0] READY_MASK = 16'h07FF;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NO_DATA = 2'd1;
	localparam logic [1:0] ST_CRC_ERR = 2'd2;

	localparam int unsigned EMA_SHIFT = 5;
	localparam logic [16:0] EMA_ROUND = 17'((1 << EMA_SHIFT) - 1);

	localparam logic [14:0] TEMP_SCALE = 15'd17500;
	localparam logic [14:0] TEMP_OFFSET = 15'd4500;
	localparam logic [13:0] HUM_SCALE = 14'd10000;

	typedef struct packed {
		logic load;
		logic fill;
	} gsfm_ctl_t;

	// crc-8 over one word, high byte first, msb first
	function automatic logic [7:0] crc8_word(input logic [15:0] word);
		logic [7:0] crc;
		logic fb;
		crc = CRC_INIT;
		for (int k = 15; k >= 0; k--) begin
			fb = crc[7] ^ word[k];
			crc = {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
		end
		return crc;
	endfunction

endpackage

@@ rtl/core/gas_sensor_frame_median_filter.sv @@
// top level: frame check, sorted history chain, average update and output register
//
// One sensor frame enters on the input channel (in_valid / in_stall) as the
// status word, the CO2, temperature and humidity words and the CRC byte of each.
// One result leaves on the output channel (out_valid / out_stall) per frame,
// in order: status, CO2 median, CO2 average, average_updated, temperature and
// humidity in hundredths. A frame with a bad CRC or no data gives status only,
// all other fields zero, and leaves history and average untouched.
// Each frame passes from stage 1 through stage 2 into the output register.
// Throughput: one frame per cycle while out_stall allows it; the history chain inserts
// and evicts one value per cycle and the average register updates once per frame.
// Three stages (check, history insert, average and scaling) each hold one frame;
// while out_stall is high the output register holds its result and the earlier
// stages keep taking frames until they are full, then in_stall rises.
// Reset (arst_n low) empties the pipeline, clears the average and marks the
// history empty; the first nonzero CO2 reading fills the history and seeds the
// average. The median reads 0 until then.
module gas_sensor_frame_median_filter #(
	parameter int unsigned HISTORY_DEPTH = gsfm_pkg::HISTORY_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,

	input logic in_valid,
	output logic in_stall,
	input logic [15:0] ready_status,
	input logic [7:0] ready_crc,
	input logic [15:0] co2_word,
	input logic [7:0] co2_crc,
	input logic [15:0] temp_word,
	input logic [7:0] temp_crc,
	input logic [15:0] hum_word,
	input logic [7:0] hum_crc,

	output logic out_valid,
	input logic out_stall,
	output logic [1:0] status,
	output logic [15:0] co2_median,
	output logic [15:0] co2_average,
	output logic average_updated,
	output logic signed [14:0] temperature_centi,
	output logic [13:0] humidity_centi
);
	import gsfm_pkg::*;

	`include "gas_sensor_frame_median_filter_macros.svh"

	// frame checks
	logic rs_ok, data_rdy, words_ok;
	logic [1:0] status_d;

	assign rs_ok = (crc8_word(ready_status) == ready_crc);
	assign data_rdy = |(ready_status & READY_MASK);
	assign words_ok = (crc8_word(co2_word) == co2_crc) && (crc8_word(temp_word) == temp_crc)
		&& (crc8_word(hum_word) == hum_crc);

	always_comb begin
		if (!rs_ok) begin
			status_d = ST_CRC_ERR;
		end else if (!data_rdy) begin
			status_d = ST_NO_DATA;
		end else if (!words_ok) begin
			status_d = ST_CRC_ERR;
		end else begin
			status_d = ST_OK;
		end
	end

	// pipeline control
	logic v_s1, v_s2, out_v_q;
	logic acc, adv2, adv3;

	assign adv3 = v_s2 && (!out_v_q || !out_stall);
	assign adv2 = v_s1 && (!v_s2 || adv3);
	assign in_stall = v_s1 && !adv2;
	assign acc = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (acc) begin
				v_s1 <= 1'b1;
			end else if (adv2) begin
				v_s1 <= 1'b0;
			end
			if (adv2) begin
				v_s2 <= 1'b1;
			end else if (adv3) begin
				v_s2 <= 1'b0;
			end
			if (adv3) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// stage 1: checked frame
	logic [1:0] status_s1;
	logic upd_s1;
	logic [15:0] co2_s1, temp_s1, hum_s1;

	always_ff @(posedge clk) begin
		if (acc) begin
			status_s1 <= status_d;
			upd_s1 <= (status_d == ST_OK) && (co2_word != 16'd0);
			co2_s1 <= co2_word;
			temp_s1 <= temp_word;
			hum_s1 <= hum_word;
		end
	end

	// history chain, updated as the frame moves into stage 2
	gsfm_ctl_t chain_ctl;
	logic [15:0] med_raw;
	logic filled;

	assign chain_ctl.load = adv2 && upd_s1;
	assign chain_ctl.fill = !filled;

	gsfm_chain #(
		.DEPTH(HISTORY_DEPTH)
	) u_chain (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(chain_ctl),
		.x(co2_s1),
		.median(med_raw),
		.filled(filled)
	);

	// stage 2: history already holds this frame
	logic [1:0] status_s2;
	logic upd_s2, seed_s2;
	logic [15:0] co2_s2, temp_s2, hum_s2;

	always_ff @(posedge clk) begin
		if (adv2) begin
			status_s2 <= status_s1;
			upd_s2 <= upd_s1;
			seed_s2 <= upd_s1 && !filled;
			co2_s2 <= co2_s1;
			temp_s2 <= temp_s1;
			hum_s2 <= hum_s1;
		end
	end

	// average moves by (median - average) / 32, toward zero
	logic [15:0] ema_q, ema_base, median_eff, ema_next;
	logic signed [16:0] delta, step;

	assign median_eff = filled ? med_raw : 16'd0;
	assign ema_base = seed_s2 ? co2_s2 : ema_q;
	assign delta = signed'({1'b0, median_eff}) - signed'({1'b0, ema_base});
	assign step = delta[16] ? ((delta + signed'(EMA_ROUND)) >>> EMA_SHIFT)
		: (delta >>> EMA_SHIFT);
	assign ema_next = 16'(signed'({1'b0, ema_base}) + step);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ema_q <= '0;
		end else if (adv3 && upd_s2) begin
			ema_q <= ema_next;
		end
	end

	// scaling to hundredths
	logic [30:0] temp_prod;
	logic [29:0] hum_prod;
	logic [14:0] temp_c;

	assign temp_prod = 31'(temp_s2) * 31'(TEMP_SCALE);
	assign hum_prod = 30'(hum_s2) * 30'(HUM_SCALE);
	assign temp_c = temp_prod[30:16] - TEMP_OFFSET;

	// output register
	logic [1:0] status_q;
	logic [15:0] median_q, average_q;
	logic updated_q;
	logic [14:0] temp_q;
	logic [13:0] hum_q;

	always_ff @(posedge clk) begin
		if (adv3) begin
			status_q <= status_s2;
			if (status_s2 == ST_OK) begin
				median_q <= median_eff;
				average_q <= upd_s2 ? ema_next : ema_q;
				updated_q <= upd_s2;
				temp_q <= temp_c;
				hum_q <= hum_prod[29:16];
			end else begin
				median_q <= '0;
				average_q <= '0;
				updated_q <= 1'b0;
				temp_q <= '0;
				hum_q <= '0;
			end
		end
	end

	assign out_valid = out_v_q;
	assign status = status_q;
	assign co2_median = median_q;
	assign co2_average = average_q;
	assign average_updated = updated_q;
	assign temperature_centi = signed'(temp_q);
	assign humidity_centi = hum_q;

	`GSFM_ASSERT_NOW(a_upd_ok, out_v_q && updated_q, status_q == ST_OK, "update on error frame")
	`GSFM_ASSERT_NOW(a_upd_med, out_v_q && updated_q, median_q != 16'd0, "zero median after update")
	`GSFM_ASSERT_NOW(a_err_zero, out_v_q && (status_q != ST_OK),
		(median_q == 16'd0) && (average_q == 16'd0), "error result carries data")
	`GSFM_ASSERT_NOW(a_hist_load, chain_ctl.load, status_s1 == ST_OK, "history load on bad frame")

endmodule

@@ rtl/core/gsfm_cell.sv @@
// one cell of the sorted history chain: value plus age, insert and evict together on one load
module gsfm_cell #(
	parameter int unsigned DEPTH = gsfm_pkg::HISTORY_DEPTH_DEF,
	parameter int unsigned IDX = 0
) (
	input logic clk,
	input gsfm_pkg::gsfm_ctl_t ctl,
	input logic [gsfm_pkg::VAL_W-1:0] x,
	input logic [gsfm_pkg::VAL_W-1:0] left_val,
	input logic [$clog2(DEPTH)-1:0] left_age,
	input logic left_del,
	input logic [gsfm_pkg::VAL_W-1:0] right_val,
	input logic [$clog2(DEPTH)-1:0] right_age,
	output logic [gsfm_pkg::VAL_W-1:0] val,
	output logic [$clog2(DEPTH)-1:0] age,
	output logic del_le
);
	import gsfm_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam logic [AW-1:0] OLDEST = AW'(DEPTH - 1);
	localparam logic [AW-1:0] FILL_AGE = AW'(IDX);
	localparam bit IS_FIRST = (IDX == 0);
	localparam bit IS_LAST = (IDX == DEPTH - 1);

	logic [VAL_W-1:0] val_q;
	logic [AW-1:0] age_q;

	logic [VAL_W-1:0] wi_val, wm_val;
	logic [AW-1:0] wi_age, wm_age;
	logic wi_ok, take_wi, take_x;

	// the evicted entry sits at or left of this cell
	assign del_le = left_del | (age_q == OLDEST);

	// entry at this place and the one before, once the oldest is removed
	assign wi_val = del_le ? right_val : val_q;
	assign wi_age = del_le ? right_age : age_q;
	assign wi_ok = !(del_le && IS_LAST);
	assign wm_val = left_del ? val_q : left_val;
	assign wm_age = left_del ? age_q : left_age;

	assign take_wi = wi_ok && (wi_val < x);
	assign take_x = IS_FIRST || (wm_val < x);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			if (ctl.fill) begin
				val_q <= x;
				age_q <= FILL_AGE;
			end else if (take_wi) begin
				val_q <= wi_val;
				age_q <= wi_age + AW'(1);
			end else if (take_x) begin
				val_q <= x;
				age_q <= '0;
			end else begin
				val_q <= wm_val;
				age_q <= wm_age + AW'(1);
			end
		end
	end

	assign val = val_q;
	assign age = age_q;

endmodule

@@ rtl/core/gsfm_chain.sv @@
// row of sorted history cells with the fill flag; the middle cell is the median
module gsfm_chain #(
	parameter int unsigned DEPTH = gsfm_pkg::HISTORY_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input gsfm_pkg::gsfm_ctl_t ctl,
	input logic [gsfm_pkg::VAL_W-1:0] x,
	output logic [gsfm_pkg::VAL_W-1:0] median,
	output logic filled
);
	import gsfm_pkg::*;

	`include "gas_sensor_frame_median_filter_macros.svh"

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned MID = (DEPTH - 1) / 2;
	localparam logic [AW-1:0] OLDEST = AW'(DEPTH - 1);

	logic [VAL_W-1:0] vals [DEPTH];
	logic [AW-1:0] ages [DEPTH];
	logic [DEPTH-1:0] dels;
	logic [DEPTH-1:0] olds;
	logic [DEPTH-2:0] ord;
	logic filled_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VAL_W-1:0] lv, rv;
		logic [AW-1:0] la, ra;
		logic ld;

		if (i == 0) begin : g_left_end
			assign lv = '0;
			assign la = '0;
			assign ld = 1'b0;
		end else begin : g_left
			assign lv = vals[i-1];
			assign la = ages[i-1];
			assign ld = dels[i-1];
		end

		if (i == DEPTH - 1) begin : g_right_end
			assign rv = '0;
			assign ra = '0;
		end else begin : g_right
			assign rv = vals[i+1];
			assign ra = ages[i+1];
		end

		gsfm_cell #(
			.DEPTH(DEPTH),
			.IDX(i)
		) u_cell (
			.clk(clk),
			.ctl(ctl),
			.x(x),
			.left_val(lv),
			.left_age(la),
			.left_del(ld),
			.right_val(rv),
			.right_age(ra),
			.val(vals[i]),
			.age(ages[i]),
			.del_le(dels[i])
		);

		assign olds[i] = (ages[i] == OLDEST);
	end

	for (genvar i = 0; i < DEPTH - 1; i++) begin : g_ord
		assign ord[i] = (vals[i] <= vals[i+1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= 1'b0;
		end else if (ctl.load) begin
			filled_q <= 1'b1;
		end
	end

	assign median = vals[MID];
	assign filled = filled_q;

	`GSFM_ASSERT_NOW(a_sorted, filled_q, &ord, "history cells out of order")
	`GSFM_ASSERT_NOW(a_one_oldest, filled_q, $onehot(olds), "not exactly one oldest entry")
	`GSFM_ASSERT_NEXT(a_fill_sticks, ctl.load || filled_q, filled_q, "fill flag lost")
	`GSFM_ASSERT_NOW(a_fill_first, ctl.load && !filled_q, ctl.fill, "insert into empty history")

endmodule
